### design/sliding_window_average_core_macros.svh
// ----------------------------------------------------------------------------
// sliding_window_average_core_macros.svh
// Assertion shorthands for the boxcar average core.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_AVERAGE_CORE_MACROS_SVH
`define SLIDING_WINDOW_AVERAGE_CORE_MACROS_SVH

// same-cycle implication
`define SWA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg
// Shared widths, constants and types of the boxcar average core.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int unsigned SMP_W          = 16;   // sample width
    localparam int unsigned AVG_W          = 16;   // average width
    localparam int unsigned WS_W           = 11;   // window register width
    localparam int unsigned FILL_W         = 11;   // fill count width
    localparam int unsigned SUM_W          = 32;   // running sum, wraps
    localparam int unsigned WCMP_W         = 17;   // holds any window limit
    localparam int unsigned MAX_WINDOW_DEF = 1024;
    localparam logic [WS_W-1:0] WS_RESET   = WS_W'(1024);

    localparam int unsigned PDATA_W = 32;
    localparam int unsigned PADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_SIZE = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,     // waiting for a sample
        S_WRAP,     // ring positions brought below the window
        S_RD,       // oldest sample back from the ring
        S_DIV       // mean in the divider
    } t_state;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [FILL_W-1:0] divisor;
    } t_div_req;

endpackage

### design/swa_sample_if.sv
// ----------------------------------------------------------------------------
// swa_sample_if
// Valid/ready channel carrying one sensor sample.
// ----------------------------------------------------------------------------
interface swa_sample_if import swa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

### design/swa_average_if.sv
// ----------------------------------------------------------------------------
// swa_average_if
// Valid/ready channel carrying one window average.
// ----------------------------------------------------------------------------
interface swa_average_if import swa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [AVG_W-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink (input valid, input average, output ready);
endinterface

### design/sliding_window_average_core.sv
// ----------------------------------------------------------------------------
// sliding_window_average_core
// Boxcar moving average of a 16-bit sample stream.
// ----------------------------------------------------------------------------
// Each accepted sample yields one result: the truncated mean of the last
// window_size samples (of all samples so far while the window fills). One
// sample is in flight at a time. From accept to result the sample passes the
// position step, the ring read, the divider (sum / fill count) and the load
// of the output register; the next sample is accepted only after that result
// is loaded. A position that steps onto the window end is brought back by one
// window length in the wrap step. After the window register is shrunk below
// the current ring positions, the wrap step takes one window length off per
// pass until the positions lie below the window. A finished result waits in
// the output register, and the next sample is accepted meanwhile; the result
// after it holds in the divider stage until the output is taken. The ring
// holds no reset or clearing pass: entries are only read after being written
// under a stable window. Write window_size (0 reads as 1, values above
// MAX_WINDOW saturate) after reset, before samples flow.
// ----------------------------------------------------------------------------
`include "sliding_window_average_core_macros.svh"

module sliding_window_average_core import swa_pkg::*; #(
    parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF   // 2 .. 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    swa_sample_if.sink         i_smp,
    swa_average_if.source      o_avg,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int unsigned POS_W = $clog2(MAX_WINDOW);
    localparam int unsigned PW1   = POS_W + 1;          // holds a position + 1
    localparam int unsigned CMP_W = (FILL_W > PW1) ? FILL_W : PW1;
    localparam logic [WCMP_W-1:0] MAX_W17 = WCMP_W'(MAX_WINDOW);

    // ---------------- configuration ----------------
    logic [WS_W-1:0] window_size;

    swa_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_window_size (window_size)
    );

    // effective window: zero counts as one, saturate at MAX_WINDOW
    logic [WCMP_W-1:0] ws_ext;
    logic [WCMP_W-1:0] w_full;
    logic [PW1-1:0]    w_eff;

    always_comb begin
        ws_ext = WCMP_W'(window_size);
        if (ws_ext == '0) begin
            w_full = WCMP_W'(1);
        end else if (ws_ext > MAX_W17) begin
            w_full = MAX_W17;
        end else begin
            w_full = ws_ext;
        end
        w_eff = w_full[PW1-1:0];
    end

    // ---------------- state ----------------
    t_state            r_state, n_state;
    logic [PW1-1:0]    r_new, n_new;       // newest slot
    logic [PW1-1:0]    r_old, n_old;       // slot before the oldest
    logic [PW1-1:0]    r_w, n_w;           // window latched for this sample
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_remove, n_remove; // window full: drop the oldest
    logic [SMP_W-1:0]  r_smp, n_smp;
    logic              r_out_valid, n_out_valid;
    logic [AVG_W-1:0]  r_avg, n_avg;

    // ring and divider hookup
    logic              mem_re;
    logic              mem_we;
    logic [SMP_W-1:0]  mem_rdata;
    t_div_req          div_req;
    logic              div_done;
    logic [AVG_W-1:0]  div_quot;

    logic              new_ge;
    logic              old_ge;
    logic              out_free;

    swa_ring_mem #(
        .DEPTH (MAX_WINDOW),
        .AW    (POS_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_new[POS_W-1:0]),
        .i_wdata (r_smp),
        .i_re    (mem_re),
        .i_raddr (r_old[POS_W-1:0]),
        .o_rdata (mem_rdata)
    );

    swa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign new_ge   = r_new >= r_w;
    assign old_ge   = r_remove && (r_old >= r_w);
    assign out_free = !r_out_valid || o_avg.ready;

    assign i_smp.ready   = (r_state == S_IDLE);
    assign o_avg.valid   = r_out_valid;
    assign o_avg.average = r_avg;

    // ---------------- control ----------------
    // The read of the oldest slot is issued in S_WRAP and the write of the
    // newest slot happens in S_RD, so with a one-sample window (same slot)
    // the old value is read before it is overwritten. Only one sample is in
    // flight, so no forwarding is needed.
    always_comb begin
        n_state     = r_state;
        n_new       = r_new;
        n_old       = r_old;
        n_w         = r_w;
        n_sum       = r_sum;
        n_fill      = r_fill;
        n_remove    = r_remove;
        n_smp       = r_smp;
        n_avg       = r_avg;
        n_out_valid = r_out_valid && !o_avg.ready;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        div_req     = '{start: 1'b0, dividend: r_sum, divisor: r_fill};

        unique case (r_state)
            S_IDLE: begin
                if (i_smp.valid) begin
                    n_smp = i_smp.sample;
                    n_w   = w_eff;
                    n_new = r_new + PW1'(1);
                    n_sum = r_sum + SUM_W'(i_smp.sample);
                    if (CMP_W'(r_fill) < CMP_W'(w_eff)) begin
                        n_fill   = r_fill + FILL_W'(1);
                        n_remove = 1'b0;
                    end else begin
                        n_old    = r_old + PW1'(1);
                        n_remove = 1'b1;
                    end
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                // modulo by repeated subtract; at most one step in steady state
                if (new_ge) begin
                    n_new = r_new - r_w;
                end
                if (old_ge) begin
                    n_old = r_old - r_w;
                end
                if (!new_ge && !old_ge) begin
                    mem_re  = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_remove) begin
                    n_sum = r_sum - SUM_W'(mem_rdata);
                end
                mem_we           = 1'b1;
                div_req.start    = 1'b1;
                div_req.dividend = n_sum;
                n_state          = S_DIV;
            end
            S_DIV: begin
                if (div_done && out_free) begin
                    n_avg       = div_quot;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_new       <= '0;
            r_old       <= '0;
            r_sum       <= '0;
            r_fill      <= '0;
            r_remove    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_new       <= n_new;
            r_old       <= n_old;
            r_sum       <= n_sum;
            r_fill      <= n_fill;
            r_remove    <= n_remove;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_smp <= n_smp;
        r_avg <= n_avg;
    end

    // ---------------- assertions ----------------
    `SWA_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_smp.valid && i_smp.ready, r_state == S_WRAP, "accepted sample did not start")
    `SWA_ASSERT_SAME(a_div_nonzero, i_clk, i_rst_n, div_req.start, r_fill != '0, "divide by zero fill count")
    `SWA_ASSERT_SAME(a_pos_wrapped, i_clk, i_rst_n, r_state == S_RD, r_new < r_w, "newest slot outside window")
    `SWA_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, (r_state == S_DIV) && div_done && out_free, r_out_valid && (r_state == S_IDLE), "finished mean not presented")

endmodule

### design/swa_ring_mem.sv
// ----------------------------------------------------------------------------
// swa_ring_mem
// Sample ring: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swa_ring_mem import swa_pkg::*; #(
    parameter int unsigned DEPTH = MAX_WINDOW_DEF,
    parameter int unsigned AW    = $clog2(MAX_WINDOW_DEF)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [SMP_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [SMP_W-1:0] o_rdata
);

    logic [SMP_W-1:0] r_mem [DEPTH];
    logic [SMP_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/swa_div.sv
// ----------------------------------------------------------------------------
// swa_div
// Restoring divider, one quotient bit per cycle; sum by fill count.
// ----------------------------------------------------------------------------
module swa_div import swa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [AVG_W-1:0] o_quot
);

    localparam int unsigned CNT_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [FILL_W-1:0] r_rem;
    logic [SUM_W-1:0]  r_dvd;     // dividend shifts out, quotient shifts in
    logic [FILL_W-1:0] r_dvs;

    logic [FILL_W:0]   trial;
    logic [FILL_W:0]   diff;
    logic              ge;

    // remainder stays below divisor, so trial < 2*divisor
    assign trial = {r_rem, r_dvd[SUM_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(SUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
            r_dvd <= {r_dvd[SUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd[AVG_W-1:0];

endmodule

### design/swa_apb_regs.sv
// ----------------------------------------------------------------------------
// swa_apb_regs
// APB register file: the window size register.
// ----------------------------------------------------------------------------
module swa_apb_regs import swa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [WS_W-1:0]    o_window_size
);

    logic [WS_W-1:0] r_ws;
    logic            wr_en;

    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= WS_RESET;
        end else if (wr_en) begin
            r_ws <= pwdata[WS_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WINDOW_SIZE: prdata = {{(PDATA_W-WS_W){1'b0}}, r_ws};
            default:         prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign o_window_size = r_ws;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the boxcar average core against a cycle-free model of the window.
// ----------------------------------------------------------------------------
// Sample requests go in over the sample channel and every average that comes
// back is compared with the mean that a model of the ring, the running sum
// and the fill count predicts. The window register is reprogrammed between
// phases while the block is idle, including zero, above-max and shrinking or
// growing the window after the ring has filled. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import swa_pkg::*;

    localparam logic [PADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW_SIZE, 2'b00};
    localparam int unsigned        SETTLE_CYC  = 64;   // quiet stretch after the drain
    localparam int unsigned        FILL_ITEMS  = 1100; // covers every ring slot
    localparam int unsigned        PHASE_ITEMS = 72;

    // ------------------------------------------------------------------------
    // Window model and expected-average store
    // ------------------------------------------------------------------------
    class boxcar_tracker;
        bit [SMP_W-1:0]  ring [MAX_WINDOW_DEF];
        int unsigned     newest_pos;
        int unsigned     oldest_pos;
        bit [SUM_W-1:0]  window_sum;
        bit [FILL_W-1:0] fill_count;
        bit [WS_W-1:0]   window_reg;
        bit [AVG_W-1:0]  expected_averages [$];
        int unsigned     errors;
        int unsigned     averages_checked;

        function new();
            newest_pos       = 0;
            oldest_pos       = 0;
            window_sum       = '0;
            fill_count       = '0;
            window_reg       = WS_RESET;
            errors           = 0;
            averages_checked = 0;
        endfunction

        function void set_window(logic [PDATA_W-1:0] value);
            window_reg = value[WS_W-1:0];
        endfunction

        // one accepted sample -> one predicted average
        function void note_sample(logic [SMP_W-1:0] value);
            int unsigned    w;
            bit [SUM_W-1:0] quot;
            w = window_reg;
            if (w == 0)
                w = 1;
            if (w > MAX_WINDOW_DEF)
                w = MAX_WINDOW_DEF;
            newest_pos = (newest_pos + 1) % w;
            window_sum = window_sum + value;
            if (fill_count < w) begin
                fill_count = fill_count + 1'b1;
            end else begin
                // window full (or shrunk under the fill): drop the oldest slot
                oldest_pos = (oldest_pos + 1) % w;
                window_sum = window_sum - ring[oldest_pos];
            end
            ring[newest_pos] = value;
            quot = window_sum / fill_count;
            expected_averages.push_back(quot[AVG_W-1:0]);
        endfunction

        function int unsigned pending();
            return expected_averages.size();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_average(logic [AVG_W-1:0] got);
            bit [AVG_W-1:0] want;
            if (expected_averages.size() == 0) begin
                report($sformatf("average 0x%04h with no request outstanding", got));
            end else begin
                want = expected_averages.pop_front();
                averages_checked++;
                if (got !== want)
                    report($sformatf("average 0x%04h, expected 0x%04h", got, want));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    swa_sample_if  smp_if ();
    swa_average_if avg_if ();

    boxcar_tracker sb;
    int unsigned   n_sent;
    int unsigned   n_settings;
    int unsigned   quiet_left;

    sliding_window_average_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_avg   (avg_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    // mostly back-to-back or short, now and then long enough to span a divide
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    // full-range values with extra weight on the rails
    function automatic logic [SMP_W-1:0] rand_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return SMP_W'($urandom_range(0, 15));
            3:       return SMP_W'(16'hFFF0 | $urandom_range(0, 15));
            default: return SMP_W'($urandom);
        endcase
    endfunction

    // called at a falling edge; leaves valid high at the falling edge after
    // acceptance so a following request can go out without a bubble
    task automatic send_sample(input logic [SMP_W-1:0] value);
        int unsigned gap;
        if (quiet_left > 0) begin
            gap = 0;
            quiet_left--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 39) == 0)
                quiet_left = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            smp_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp_if.valid  = 1'b1;
        smp_if.sample = value;
        do @(posedge i_clk); while (!smp_if.ready);
        sb.note_sample(value);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = WINDOW_ADDR;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_window(data);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // read back the window register and compare with the model's copy
    task automatic apb_check_window();
        logic [PDATA_W-1:0] got;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = WINDOW_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got[WS_W-1:0] !== sb.window_reg)
            sb.report($sformatf("window readback 0x%0h, expected 0x%0h",
                                got[WS_W-1:0], sb.window_reg));
    endtask

    // drain: every average back, then let the block fall idle
    task automatic settle();
        smp_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic reprogram(input logic [PDATA_W-1:0] data);
        settle();
        apb_write(data);
        apb_check_window();
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Average sink: ready toggles in stall/accept runs, long open runs too
    // ------------------------------------------------------------------------
    initial begin
        int unsigned stall;
        int unsigned run;
        avg_if.ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n)
            @(negedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                avg_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 800)
                                              : $urandom_range(1, 60);
            avg_if.ready = 1'b1;
            repeat (run) @(negedge i_clk);
        end
    end

    // results are taken at the rising edge where valid and ready meet
    always @(posedge i_clk) begin
        if (i_rst_n && avg_if.valid && avg_if.ready)
            sb.check_average(avg_if.average);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [SMP_W-1:0]   directed [24];
        logic [PDATA_W-1:0] settings [9];

        sb         = new();
        n_sent     = 0;
        n_settings = 0;
        quiet_left = 0;

        i_rst_n       = 1'b0;
        smp_if.valid  = 1'b0;
        smp_if.sample = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        directed = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFE,
                     16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h00FF, 16'hFF00,
                     16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC, 16'h0002, 16'hFFFD};

        // later windows: zero (acts as one), small, exact max, near max,
        // random including values that saturate
        settings = '{32'hFFFF_F800, 32'd1, 32'd2, 32'd1024, 32'd3,
                     PDATA_W'($urandom_range(1, 64)), 32'd1023, $urandom, 32'd7};

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset value first, then above-max with junk upper bits (saturates)
        apb_check_window();
        reprogram(32'hFFFF_FFFF);

        // directed rails and bit patterns during warm-up
        foreach (directed[i])
            send_sample(directed[i]);

        // fill well past one full window so every ring slot has been written
        // before the window is changed under a live stream
        while (n_sent < FILL_ITEMS)
            send_sample(rand_sample());

        // window changed after samples have flowed: shrink, grow, extremes
        foreach (settings[i]) begin
            reprogram(settings[i]);
            repeat (PHASE_ITEMS)
                send_sample(rand_sample());
        end

        // final drain plus a quiet stretch to catch stray results
        settle();

        $display("Sent %0d samples under %0d window settings; %0d averages checked.",
                 n_sent, n_settings, sb.averages_checked);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin
        #10_000_000;
        $display("Timeout with %0d averages outstanding", sb.pending());
        $display("Verification failed");
        $finish;
    end

endmodule
